// ----- design/pie_pkg.sv -----
// shared types and constants for the positional insert/erase list
// no dependencies; imported by every module of the block except pie_ram
`timescale 1ns / 1ps
`default_nettype none

package pie_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int KIND_W      = 3;
  localparam int POS_W       = 5;
  localparam int VAL_W       = 32;
  localparam int CNT_OUT_W   = 5;
  localparam int STAT_W      = 2;
  localparam int IN_DATA_W   = 40;  // position, data_value, padded to bytes
  localparam int OUT_DATA_W  = 40;  // read_value, entry_count, padded to bytes

  typedef enum logic [KIND_W-1:0] {
    K_PUSH_BACK  = 3'd0,
    K_PUSH_FRONT = 3'd1,
    K_POP_BACK   = 3'd2,
    K_POP_FRONT  = 3'd3,
    K_INSERT     = 3'd4,
    K_ERASE      = 3'd5,
    K_READ_AT    = 3'd6,
    K_READ_LAST  = 3'd7
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2,
    STS_POS   = 2'd3
  } status_e;

  // what the datapath has to do with the store for the accepted word
  typedef enum logic [2:0] {
    PLAN_NONE   = 3'd0,
    PLAN_APPEND = 3'd1,
    PLAN_OPEN   = 3'd2,
    PLAN_CLOSE  = 3'd3,
    PLAN_READ   = 3'd4
  } plan_e;

  typedef enum logic [2:0] {
    S_IDLE    = 3'd0,
    S_PLAN    = 3'd1,
    S_MOVE_RD = 3'd2,
    S_MOVE_WR = 3'd3,
    S_PUT     = 3'd4,
    S_FETCH   = 3'd5,
    S_DONE    = 3'd6
  } state_e;

  typedef struct packed {
    logic take;      // latch the input word and decode it
    logic rd_move;   // read the neighbor of the shift pointer
    logic wr_move;   // write it at the shift pointer and step
    logic wr_new;    // write the new value at the target slot
    logic rd_fetch;  // read the target slot
    logic finish;    // load the result register, commit the count
  } pie_cmd_t;

  typedef struct packed {
    plan_e plan;
    logic  move_left;  // shift pointer has not reached its end
    logic  out_free;   // result register can take a new word
  } pie_stat_t;

endpackage

`default_nettype wire

// ----- design/pie_ram.sv -----
// generic single write port ram with a registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- design/pie_dp.sv -----
// datapath: operation decode, count, shift pointer, store ram, result register
// depends on pie_pkg and pie_ram
`timescale 1ns / 1ps
`default_nettype none

module pie_dp #(
  parameter int CAPACITY = pie_pkg::CAPACITY_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [pie_pkg::KIND_W-1:0]     kind_i,
  input  wire logic [pie_pkg::POS_W-1:0]      position_i,
  input  wire logic [pie_pkg::VAL_W-1:0]      data_value_i,
  input  wire pie_pkg::pie_cmd_t              cmd_i,
  output      pie_pkg::pie_stat_t             stat_o,
  input  wire logic                           out_ready_i,
  output      logic                           out_valid_o,
  output      logic [pie_pkg::VAL_W-1:0]      read_value_o,
  output      logic [pie_pkg::CNT_OUT_W-1:0]  entry_count_o,
  output      logic [pie_pkg::STAT_W-1:0]     status_o
);

  import pie_pkg::*;

  localparam int AddrW = $clog2(CAPACITY);
  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int CmpW  = ((CntW > POS_W) ? CntW : POS_W) + 1;

  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  ptr_q, ptr_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [VAL_W-1:0] data_q;
  plan_e            plan_q, plan_d;
  status_e          sts_q, sts_d;
  logic             inc_q, inc_d, dec_q, dec_d;

  logic             out_valid_q;
  logic [VAL_W-1:0] out_value_q;
  logic [CNT_OUT_W-1:0] out_count_q;
  status_e          out_sts_q;

  logic [CmpW-1:0]  cnt_w, pos_w, idx_w;
  logic             full, empty, ins_ok, pos_ok;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [VAL_W-1:0] ram_wdata, ram_rdata;
  logic [CntW-1:0]  ptr_nb, ptr_step;
  logic [CntW-1:0]  count_new;
  logic [CmpW-1:0]  count_new_w;

  // decode of the incoming word against the current count
  always_comb begin
    cnt_w  = CmpW'(count_q);
    pos_w  = CmpW'(position_i);
    full   = (count_q == CntW'(CAPACITY));
    empty  = (count_q == '0);
    ins_ok = (pos_w != '0) && (pos_w <= cnt_w + CmpW'(1));
    pos_ok = (pos_w != '0) && (pos_w <= cnt_w);
    sts_d  = STS_OK;
    plan_d = PLAN_NONE;
    inc_d  = 1'b0;
    dec_d  = 1'b0;
    idx_w  = pos_w - CmpW'(1);
    case (kind_e'(kind_i))
      K_PUSH_BACK: begin
        idx_w = cnt_w;
        if (full) sts_d = STS_FULL;
        else begin
          plan_d = PLAN_APPEND;
          inc_d  = 1'b1;
        end
      end
      K_PUSH_FRONT: begin
        idx_w = '0;
        if (full) sts_d = STS_FULL;
        else begin
          plan_d = PLAN_OPEN;
          inc_d  = 1'b1;
        end
      end
      K_POP_BACK: begin
        if (empty) sts_d = STS_EMPTY;
        else dec_d = 1'b1;
      end
      K_POP_FRONT: begin
        idx_w = '0;
        if (empty) sts_d = STS_EMPTY;
        else begin
          plan_d = PLAN_CLOSE;
          dec_d  = 1'b1;
        end
      end
      K_INSERT: begin
        if (full) sts_d = STS_FULL;
        else if (!ins_ok) sts_d = STS_POS;
        else begin
          plan_d = PLAN_OPEN;
          inc_d  = 1'b1;
        end
      end
      K_ERASE: begin
        if (empty) sts_d = STS_EMPTY;
        else if (!pos_ok) sts_d = STS_POS;
        else begin
          plan_d = PLAN_CLOSE;
          dec_d  = 1'b1;
        end
      end
      K_READ_AT: begin
        if (empty) sts_d = STS_EMPTY;
        else if (!pos_ok) sts_d = STS_POS;
        else plan_d = PLAN_READ;
      end
      K_READ_LAST: begin
        idx_w = cnt_w - CmpW'(1);
        if (empty) sts_d = STS_EMPTY;
        else plan_d = PLAN_READ;
      end
      default: begin
        sts_d = STS_OK;
      end
    endcase
    idx_d = idx_w[AddrW-1:0];
  end

  // shift pointer: opening walks down from the count, closing walks up from idx
  always_comb begin
    ptr_nb   = (plan_q == PLAN_OPEN) ? (ptr_q - CntW'(1)) : (ptr_q + CntW'(1));
    ptr_step = ptr_nb;
    ptr_d    = ptr_q;
    if (cmd_i.take) begin
      ptr_d = (plan_d == PLAN_OPEN) ? count_q : CntW'(idx_d);
    end else if (cmd_i.wr_move) begin
      ptr_d = ptr_step;
    end
  end

  assign stat_o.plan      = plan_q;
  assign stat_o.move_left = (plan_q == PLAN_OPEN)
                            ? (ptr_q != CntW'(idx_q))
                            : ({1'b0, ptr_q} + (CntW+1)'(1) < {1'b0, count_q});
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign ram_re    = cmd_i.rd_move || cmd_i.rd_fetch;
  assign ram_raddr = cmd_i.rd_fetch ? idx_q : ptr_nb[AddrW-1:0];
  assign ram_we    = cmd_i.wr_move || cmd_i.wr_new;
  assign ram_waddr = cmd_i.wr_move ? ptr_q[AddrW-1:0] : idx_q;
  assign ram_wdata = cmd_i.wr_move ? ram_rdata : data_q;

  pie_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    count_new   = count_q + CntW'(inc_q) - CntW'(dec_q);
    count_new_w = CmpW'(count_new);
    count_d     = cmd_i.finish ? count_new : count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      plan_q      <= PLAN_NONE;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.take) plan_q <= plan_d;
      if (cmd_i.finish) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.take) begin
      idx_q  <= idx_d;
      data_q <= data_value_i;
      sts_q  <= sts_d;
      inc_q  <= inc_d;
      dec_q  <= dec_d;
    end
    if (cmd_i.finish) begin
      out_value_q <= (plan_q == PLAN_READ) ? ram_rdata : '0;
      out_count_q <= count_new_w[CNT_OUT_W-1:0];
      out_sts_q   <= sts_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = out_value_q;
  assign entry_count_o = out_count_q;
  assign status_o      = out_sts_q;

endmodule

`default_nettype wire

// ----- design/pie_ctrl.sv -----
// controller state machine sequencing the store accesses of one word
// depends on pie_pkg
`timescale 1ns / 1ps
`default_nettype none

module pie_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire pie_pkg::pie_stat_t stat_i,
  output      pie_pkg::pie_cmd_t  cmd_o
);

  import pie_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_PLAN;
        end
      end
      // also the loop check after each moved entry
      S_PLAN: begin
        case (stat_i.plan)
          PLAN_APPEND: state_d = S_PUT;
          PLAN_OPEN:   state_d = stat_i.move_left ? S_MOVE_RD : S_PUT;
          PLAN_CLOSE:  state_d = stat_i.move_left ? S_MOVE_RD : S_DONE;
          PLAN_READ:   state_d = S_FETCH;
          default:     state_d = S_DONE;
        endcase
      end
      S_MOVE_RD: begin
        cmd_o.rd_move = 1'b1;
        state_d       = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        cmd_o.wr_move = 1'b1;
        state_d       = S_PLAN;
      end
      S_PUT: begin
        cmd_o.wr_new = 1'b1;
        state_d      = S_DONE;
      end
      S_FETCH: begin
        cmd_o.rd_fetch = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/positional_insert_erase_list_top.sv -----
// top level of the positional insert/erase list: stream ports, controller, datapath
// depends on pie_pkg, pie_ctrl, pie_dp (and through it pie_ram)
//
// channel  | dir | tdata (low bit up)                 | tuser
// ---------+-----+------------------------------------+------------------
// s_axis   | in  | position[4:0], data_value[36:5]    | kind[2:0]
// m_axis   | out | read_value[31:0], entry_count[36:32] | status[1:0]
//
// one word at a time; from accept to next accept:
//   pop back / failed ops: go to the result, push back: write the new value,
//   reads: fetch the slot, push front / insert: move n entries up, then write,
//   pop front / erase: move n entries down; each move is a ram read then a write
// reset clears the count and the control; the store is not cleared
// a stalled result waits in the output register while the next word is taken;
// that word finishes once the register frees
`timescale 1ns / 1ps
`default_nettype none

module positional_insert_erase_list_top #(
  parameter int CAPACITY = pie_pkg::CAPACITY_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  input  wire logic [pie_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // position, data_value
  input  wire logic [pie_pkg::KIND_W-1:0]      s_axis_tuser,   // kind
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output      logic [pie_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // read_value, entry_count
  output      logic [pie_pkg::STAT_W-1:0]      m_axis_tuser    // status
);

  import pie_pkg::*;

  pie_cmd_t              cmd;
  pie_stat_t             stat;
  logic [VAL_W-1:0]      read_value;
  logic [CNT_OUT_W-1:0]  entry_count;

  // sequencer
  pie_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // decode, store and result register
  pie_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .kind_i        (s_axis_tuser),
    .position_i    (s_axis_tdata[POS_W-1:0]),
    .data_value_i  (s_axis_tdata[POS_W+VAL_W-1:POS_W]),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .read_value_o  (read_value),
    .entry_count_o (entry_count),
    .status_o      (m_axis_tuser)
  );

  // pack the result word, zero pad to whole bytes
  assign m_axis_tdata = {{(OUT_DATA_W - VAL_W - CNT_OUT_W){1'b0}}, entry_count, read_value};

endmodule

`default_nettype wire

// ----- design/pie_checker.sv -----
// port level checks for the positional insert/erase list, bound to the top level
// depends on pie_pkg and positional_insert_erase_list_top
`timescale 1ns / 1ps
`default_nettype none

module pie_checker #(
  parameter int CAPACITY = pie_pkg::CAPACITY_DEF
) (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [pie_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input wire logic [pie_pkg::STAT_W-1:0]      m_axis_tuser
);

  import pie_pkg::*;

  localparam logic [CNT_OUT_W-1:0] CapMod = CNT_OUT_W'(CAPACITY);

  // one word in flight: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("word accepted while previous word still in work");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  // failed operations read nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != STS_OK)) |-> (m_axis_tdata[VAL_W-1:0] == '0))
    else $error("nonzero read value with bad status");

  // empty status only on an empty list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == STS_EMPTY)) |->
      (m_axis_tdata[VAL_W+CNT_OUT_W-1:VAL_W] == '0))
    else $error("empty status with nonzero count");

  // full status only on a full list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == STS_FULL)) |->
      (m_axis_tdata[VAL_W+CNT_OUT_W-1:VAL_W] == CapMod))
    else $error("full status with count below capacity");

endmodule

bind positional_insert_erase_list_top pie_checker #(
  .CAPACITY (CAPACITY)
) u_pie_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
